// ===== rtl/ga2d_pkg.sv =====
// ----------------------------------------------------------------------------
// Gravity acceleration package
// Shared payload types, register indexes and constants of the gravity core.
// ----------------------------------------------------------------------------
package ga2d_pkg;

  localparam int FRAC_BITS_DEF = 24;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY = 8'd1;

  localparam logic [30:0] GRAVITY_RST = 31'd503316;
  localparam logic [30:0] DENSITY_RST = 31'd3355443;

  localparam logic [63:0] FOUR_THIRDS_PI_Q31 = 64'd8995358470;
  localparam logic [30:0] MAG_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] body_x;
    logic signed [31:0] body_y;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic        [30:0] source_radius;
    logic               source_repels;
  } in_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic               saturated;
  } out_t;

  // Rounded 4/3*pi with f fraction bits.
  function automatic logic [63:0] four_thirds_pi(int f);
    logic [63:0] v;
    v = (FOUR_THIRDS_PI_Q31 >> (30 - f)) + 64'd1;
    return v >> 1;
  endfunction

endpackage

// ===== rtl/gravity_acceleration_2d_core.sv =====
// ----------------------------------------------------------------------------
// Gravity acceleration core
// Point-mass gravity of one source on one body in the plane, fixed point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o   | in_data_i (in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request enters per cycle while in_stall_o is low; the pipeline length is
// set by the bit-per-stage square root (33 stages) and the bit-per-stage
// quotient of the magnitude (64 stages).
// Reset clears the valid bits of all stages and loads the register defaults.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up and a stalled output does not stop the input at once.
module gravity_acceleration_2d_core
  import ga2d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [30:0]          cfg_data_i
);

  localparam int K_END     = 15;
  localparam int SQ_START  = 3;
  localparam int SQ_BITS   = 33;
  localparam int DIV_INIT  = SQ_START + SQ_BITS;
  localparam int DIV_START = DIV_INIT + 1;
  localparam int DIV_BITS  = 64;
  localparam int MUL_STG   = DIV_START + DIV_BITS;
  localparam int CLAMP_STG = MUL_STG + 1;
  localparam int OUT_STG   = CLAMP_STG + 1;
  localparam int N_STAGES  = OUT_STG + 1;

  localparam logic [63:0] FTP = four_thirds_pi(FRAC_BITS);

  typedef struct packed {
    logic [32:0]  ax;
    logic [32:0]  ay;
    logic         negx;
    logic         negy;
    logic         zero;
    logic         sat;
    logic [30:0]  r;
    logic [63:0]  k;
    logic [63:0]  p00;
    logic [63:0]  p01;
    logic [63:0]  p10;
    logic [63:0]  p11;
    logic [127:0] wsum;
    logic [65:0]  sqx;
    logic [65:0]  sqy;
    logic [65:0]  d2;
    logic [34:0]  srem;
    logic [32:0]  root;
    logic [65:0]  arem;
    logic [63:0]  aquot;
    logic         aovf;
    logic [32:0]  urx;
    logic [32:0]  ury;
    logic [30:0]  uqx;
    logic [30:0]  uqy;
    logic [30:0]  magx;
    logic [30:0]  magy;
    logic [31:0]  ox;
    logic [31:0]  oy;
  } st_t;

  logic [30:0] gravity_q;
  logic [30:0] density_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GRAVITY_RST;
      density_q <= DENSITY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRAVITY: gravity_q <= cfg_data_i;
        CFG_DENSITY: density_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic st_t first_stage(in_t d);
    st_t n;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    n = '0;
    dx = {d.body_x[31], d.body_x} - {d.source_x[31], d.source_x};
    dy = {d.body_y[31], d.body_y} - {d.source_y[31], d.source_y};
    n.ax = dx[32] ? 33'(-dx) : 33'(dx);
    n.ay = dy[32] ? 33'(-dy) : 33'(dy);
    n.negx = (dx[32] == d.source_repels);
    n.negy = (dy[32] == d.source_repels);
    n.zero = (dx == 33'sd0) && (dy == 33'sd0);
    n.r = d.source_radius;
    return n;
  endfunction

  // Returns the new remainder and quotient of one bit of the unit vector
  // division.
  function automatic logic [63:0] unit_step(logic [32:0] rem, logic [30:0] quo,
                                            logic b, logic [32:0] d);
    logic [33:0] t;
    logic        q;
    t = {rem, b};
    q = (t >= {1'b0, d});
    if (q) begin
      t = t - {1'b0, d};
    end
    return {t[32:0], quo[29:0], q};
  endfunction

  function automatic st_t next_stage(int k, int qi, int qp, st_t s,
                                     logic [30:0] g, logic [30:0] rho);
    st_t          n;
    int           j;
    logic [63:0]  opa;
    logic [63:0]  opb;
    logic [127:0] w;
    logic [65:0]  d2sh;
    logic [36:0]  t37;
    logic [34:0]  trial;
    logic [63:0]  nh;
    logic [63:0]  numlo;
    logic [66:0]  t67;
    logic         qb;
    logic         ub;
    logic [63:0]  ustep;
    logic [63:0]  amag;
    logic [95:0]  w96;
    n = s;
    if (k == 1) begin
      n.sqx = s.ax * s.ax;
      n.sqy = s.ay * s.ay;
    end
    if (k == 2) begin
      n.d2 = s.sqx + s.sqy;
      n.srem = '0;
      n.root = '0;
    end
    if (k >= 1 && k <= K_END) begin
      opa = (qi == 0) ? {33'b0, s.r} : s.k;
      case (qi)
        0: opb = {33'b0, s.r};
        1: opb = {33'b0, s.r};
        2: opb = FTP;
        3: opb = {33'b0, rho};
        default: opb = {33'b0, g};
      endcase
      if (qp == 0) begin
        n.p00 = opa[31:0] * opb[31:0];
        n.p01 = opa[31:0] * opb[63:32];
        n.p10 = opa[63:32] * opb[31:0];
        n.p11 = opa[63:32] * opb[63:32];
      end else if (qp == 1) begin
        n.wsum = {64'b0, s.p00} + {32'b0, s.p01, 32'b0} + {32'b0, s.p10, 32'b0}
               + {s.p11, 64'b0};
      end else begin
        w = s.wsum >> FRAC_BITS;
        if (|w[127:64]) begin
          n.k = '1;
          n.sat = 1'b1;
        end else begin
          n.k = w[63:0];
        end
      end
    end
    if (k >= SQ_START && k < SQ_START + SQ_BITS) begin
      j = k - SQ_START;
      d2sh = s.d2 >> (64 - 2 * j);
      t37 = {s.srem, d2sh[1:0]};
      trial = {s.root, 2'b01};
      if (t37 >= {2'b0, trial}) begin
        t37 = t37 - {2'b0, trial};
        n.root = {s.root[31:0], 1'b1};
      end else begin
        n.root = {s.root[31:0], 1'b0};
      end
      n.srem = t37[34:0];
    end
    if (k == DIV_INIT) begin
      nh = s.k >> (64 - 2 * FRAC_BITS);
      n.aovf = ({2'b0, nh} >= s.d2);
      n.arem = {2'b0, nh};
      n.aquot = '0;
      n.urx = s.ax >> 1;
      n.ury = s.ay >> 1;
      n.uqx = '0;
      n.uqy = '0;
    end
    if (k >= DIV_START && k < DIV_START + DIV_BITS) begin
      j = k - DIV_START;
      numlo = s.k << (2 * FRAC_BITS);
      numlo = numlo >> (63 - j);
      t67 = {s.arem, numlo[0]};
      qb = (t67 >= {1'b0, s.d2});
      if (qb) begin
        t67 = t67 - {1'b0, s.d2};
      end
      n.arem = t67[65:0];
      n.aquot = {s.aquot[62:0], qb};
      if (j <= FRAC_BITS) begin
        ub = (j == 0) ? s.ax[0] : 1'b0;
        ustep = unit_step(s.urx, s.uqx, ub, s.root);
        n.urx = ustep[63:31];
        n.uqx = ustep[30:0];
        ub = (j == 0) ? s.ay[0] : 1'b0;
        ustep = unit_step(s.ury, s.uqy, ub, s.root);
        n.ury = ustep[63:31];
        n.uqy = ustep[30:0];
      end
    end
    if (k == MUL_STG) begin
      amag = s.aovf ? '1 : s.aquot;
      n.sat = s.sat | s.aovf;
      n.p00 = amag[31:0] * s.uqx;
      n.p01 = amag[63:32] * s.uqx;
      n.p10 = amag[31:0] * s.uqy;
      n.p11 = amag[63:32] * s.uqy;
    end
    if (k == CLAMP_STG) begin
      w96 = ({32'b0, s.p00} + {s.p01, 32'b0}) >> FRAC_BITS;
      if (|w96[95:31]) begin
        n.magx = MAG_MAX;
        n.sat = 1'b1;
      end else begin
        n.magx = w96[30:0];
      end
      w96 = ({32'b0, s.p10} + {s.p11, 32'b0}) >> FRAC_BITS;
      if (|w96[95:31]) begin
        n.magy = MAG_MAX;
        n.sat = 1'b1;
      end else begin
        n.magy = w96[30:0];
      end
    end
    if (k == OUT_STG) begin
      n.ox = s.negx ? (32'd0 - {1'b0, s.magx}) : {1'b0, s.magx};
      n.oy = s.negy ? (32'd0 - {1'b0, s.magy}) : {1'b0, s.magy};
      if (s.zero) begin
        n.ox = '0;
        n.oy = '0;
        n.sat = 1'b1;
      end
    end
    return n;
  endfunction

  logic [N_STAGES-1:0] v_q;
  logic [N_STAGES:0]   en;
  st_t                 st_q [N_STAGES];
  st_t                 st_d [N_STAGES];

  assign en[N_STAGES] = !out_stall_i;
  assign in_stall_o   = !en[0];

  for (genvar gk = 0; gk < N_STAGES; gk++) begin : g_stage
    localparam int QI = (gk - 1) / 3;
    localparam int QP = (gk - 1) % 3;

    assign en[gk] = !v_q[gk] || en[gk+1];

    if (gk == 0) begin : g_first
      always_comb begin
        st_d[gk] = first_stage(in_data_i);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[gk] <= 1'b0;
        end else if (en[gk]) begin
          v_q[gk] <= in_valid_i;
        end
      end
    end else begin : g_rest
      always_comb begin
        st_d[gk] = next_stage(gk, QI, QP, st_q[gk-1], gravity_q, density_q);
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[gk] <= 1'b0;
        end else if (en[gk]) begin
          v_q[gk] <= v_q[gk-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[gk]) begin
        st_q[gk] <= st_d[gk];
      end
    end
  end

  assign out_valid_o          = v_q[N_STAGES-1];
  assign out_data_o.accel_x   = st_q[N_STAGES-1].ox;
  assign out_data_o.accel_y   = st_q[N_STAGES-1].oy;
  assign out_data_o.saturated = st_q[N_STAGES-1].sat;

endmodule

// ===== rtl/ga2d_checker.sv =====
// ----------------------------------------------------------------------------
// Gravity acceleration checker
// Port-level assertions for the gravity core, bound to its top level.
// ----------------------------------------------------------------------------
module ga2d_checker
  import ga2d_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Stalled result changed.");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the pipeline could move.");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.accel_x != 32'sh8000_0000 &&
                    out_data_o.accel_y != 32'sh8000_0000)
    else $error("Component beyond the symmetric limit.");

endmodule

bind gravity_acceleration_2d_core ga2d_checker u_ga2d_checker (.*);
